[rtl/bat_pkg.sv]
// shared types, constants and saturation helper for the backstepping attitude torque block
// no dependencies; used by bat_lane, bat_merge and backstepping_attitude_torque
`timescale 1ns / 1ps

package bat_pkg;

    // pipeline depth: axis lane stages plus the merge/output register
    localparam int LANE_STAGES = 12;
    localparam int NSTAGE      = LANE_STAGES + 1;

    // configuration port
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [2:0] REG_INERTIA_ROLL  = 3'd0;
    localparam logic [2:0] REG_INERTIA_PITCH = 3'd1;
    localparam logic [2:0] REG_INERTIA_YAW   = 3'd2;
    localparam logic [2:0] REG_GAIN_VELOCITY = 3'd3;
    localparam logic [2:0] REG_GAIN_ATTITUDE = 3'd4;
    localparam logic [2:0] REG_OUTPUT_SCALE  = 3'd5;

    localparam logic [27:0] INERTIA_RST = 28'd167772;
    localparam logic [23:0] GAIN_RST    = 24'd0;
    localparam logic [23:0] SCALE_RST   = 24'd65536;

    // intermediate saturation bound +-2^62
    localparam logic signed [67:0] SAT_LIM_P = 68'sh0_4000_0000_0000_0000;
    localparam logic signed [67:0] SAT_LIM_N = -SAT_LIM_P;

    typedef struct packed {
        logic [NSTAGE-1:0] en;
    } t_pipe_ctl;

    typedef struct packed {
        logic [23:0] kv;
        logic [23:0] ka;
        logic [23:0] scale;
    } t_gain_cfg;

    typedef struct packed {
        logic [27:0] inertia;
        logic [27:0] inertia_a;
        logic [27:0] inertia_b;
    } t_axis_cfg;

    function automatic logic signed [63:0] clamp62(input logic signed [67:0] x);
        logic signed [63:0] y;
        if (x > SAT_LIM_P) begin
            y = 64'(SAT_LIM_P);
        end else if (x < SAT_LIM_N) begin
            y = 64'(SAT_LIM_N);
        end else begin
            y = 64'(x);
        end
        return y;
    endfunction

endpackage

[rtl/backstepping_attitude_torque.sv]
// top level of the quaternion backstepping attitude torque block
// depends on bat_pkg, bat_lane and bat_merge
`timescale 1ns / 1ps

// Turns one sample of body rates, measured and goal attitude quaternions and
// collective thrust into roll, pitch and yaw torque setpoints (Q16.16,
// saturated to 32 bits) plus the thrust passed through. Three axis lanes run
// side by side, each a 12-stage multiply pipeline, and a merge stage clamps
// and registers the result beat. The edge that accepts a sample loads the
// first lane stage; the beat then moves through the other lane stages and
// o_valid rises once it reaches the merge register. The block takes one
// sample every cycle as long as the output side keeps up. Each pipeline
// stage holds when the one after it is full and stalled, so bubbles close up
// and o_stall rises only once every stage holds a beat. The six gain and
// inertia registers sit on an APB-style port with byte addresses 0x00..0x14
// and are to be written only while no beat is in flight.
module backstepping_attitude_torque (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bat_pkg::ADDR_W-1:0]    paddr,
    input  logic [bat_pkg::DATA_W-1:0]    pwdata,
    output logic [bat_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    // input channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [15:0]            i_att_w,
    input  logic signed [15:0]            i_att_x,
    input  logic signed [15:0]            i_att_y,
    input  logic signed [15:0]            i_att_z,
    input  logic signed [15:0]            i_goal_w,
    input  logic signed [15:0]            i_goal_x,
    input  logic signed [15:0]            i_goal_y,
    input  logic signed [15:0]            i_goal_z,
    input  logic signed [21:0]            i_rate_roll,
    input  logic signed [21:0]            i_rate_pitch,
    input  logic signed [21:0]            i_rate_yaw,
    input  logic signed [15:0]            i_thrust_in,
    // output channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [31:0]            o_torque_roll,
    output logic signed [31:0]            o_torque_pitch,
    output logic signed [31:0]            o_torque_yaw,
    output logic signed [15:0]            o_thrust_out
);

    localparam int NS = bat_pkg::NSTAGE;
    localparam int LS = bat_pkg::LANE_STAGES;

    // ---------------- configuration registers ----------------
    logic [27:0] r_inertia_roll;
    logic [27:0] r_inertia_pitch;
    logic [27:0] r_inertia_yaw;
    logic [23:0] r_gain_velocity;
    logic [23:0] r_gain_attitude;
    logic [23:0] r_output_scale;

    logic        w_cfg_wr;
    logic [2:0]  w_cfg_idx;

    assign w_cfg_wr  = psel && penable && pwrite;
    assign w_cfg_idx = paddr[4:2];
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inertia_roll  <= bat_pkg::INERTIA_RST;
            r_inertia_pitch <= bat_pkg::INERTIA_RST;
            r_inertia_yaw   <= bat_pkg::INERTIA_RST;
            r_gain_velocity <= bat_pkg::GAIN_RST;
            r_gain_attitude <= bat_pkg::GAIN_RST;
            r_output_scale  <= bat_pkg::SCALE_RST;
        end else if (w_cfg_wr) begin
            case (w_cfg_idx)
                bat_pkg::REG_INERTIA_ROLL:  r_inertia_roll  <= pwdata[27:0];
                bat_pkg::REG_INERTIA_PITCH: r_inertia_pitch <= pwdata[27:0];
                bat_pkg::REG_INERTIA_YAW:   r_inertia_yaw   <= pwdata[27:0];
                bat_pkg::REG_GAIN_VELOCITY: r_gain_velocity <= pwdata[23:0];
                bat_pkg::REG_GAIN_ATTITUDE: r_gain_attitude <= pwdata[23:0];
                bat_pkg::REG_OUTPUT_SCALE:  r_output_scale  <= pwdata[23:0];
                default: begin
                    // addresses past the register list are ignored
                end
            endcase
        end
    end

    // read mux, unused addresses read as zero
    always_comb begin
        case (w_cfg_idx)
            bat_pkg::REG_INERTIA_ROLL:  prdata = 32'(r_inertia_roll);
            bat_pkg::REG_INERTIA_PITCH: prdata = 32'(r_inertia_pitch);
            bat_pkg::REG_INERTIA_YAW:   prdata = 32'(r_inertia_yaw);
            bat_pkg::REG_GAIN_VELOCITY: prdata = 32'(r_gain_velocity);
            bat_pkg::REG_GAIN_ATTITUDE: prdata = 32'(r_gain_attitude);
            bat_pkg::REG_OUTPUT_SCALE:  prdata = 32'(r_output_scale);
            default:                    prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    // one valid bit per stage; the last one is the output register
    logic [NS-1:0]       r_v;
    logic [NS-1:0]       n_v;
    bat_pkg::t_pipe_ctl  w_ctl;

    // a stage loads when it is empty or its successor moves on
    always_comb begin
        w_ctl.en[NS-1] = !r_v[NS-1] || !i_stall;
        for (int k = NS - 2; k >= 0; k--) begin
            w_ctl.en[k] = !r_v[k] || w_ctl.en[k+1];
        end
    end

    always_comb begin
        n_v[0] = w_ctl.en[0] ? i_valid : r_v[0];
        for (int k = 1; k < NS; k++) begin
            n_v[k] = w_ctl.en[k] ? r_v[k-1] : r_v[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    assign o_stall = !w_ctl.en[0];
    assign o_valid = r_v[NS-1];

    // thrust rides alongside the lanes
    logic signed [15:0] r_thrust [LS];

    always_ff @(posedge i_clk) begin
        if (w_ctl.en[0]) begin
            r_thrust[0] <= i_thrust_in;
        end
        for (int k = 1; k < LS; k++) begin
            if (w_ctl.en[k]) begin
                r_thrust[k] <= r_thrust[k-1];
            end
        end
    end

    // ---------------- axis lanes ----------------
    bat_pkg::t_gain_cfg w_gain;
    bat_pkg::t_axis_cfg w_axis_roll;
    bat_pkg::t_axis_cfg w_axis_pitch;
    bat_pkg::t_axis_cfg w_axis_yaw;

    assign w_gain.kv    = r_gain_velocity;
    assign w_gain.ka    = r_gain_attitude;
    assign w_gain.scale = r_output_scale;

    // gyroscopic inertia differences: roll Iy-Iz, pitch Iz-Ix, yaw Ix-Iy
    assign w_axis_roll  = '{inertia: r_inertia_roll,  inertia_a: r_inertia_pitch,
                            inertia_b: r_inertia_yaw};
    assign w_axis_pitch = '{inertia: r_inertia_pitch, inertia_a: r_inertia_yaw,
                            inertia_b: r_inertia_roll};
    assign w_axis_yaw   = '{inertia: r_inertia_yaw,   inertia_a: r_inertia_roll,
                            inertia_b: r_inertia_pitch};

    logic signed [47:0] w_tq_roll, w_tq_pitch, w_tq_yaw;

    // error term uses the axis component and the cyclic pair after it
    bat_lane u_lane_roll (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_gain   (w_gain),
        .i_axis   (w_axis_roll),
        .i_goal_w (i_goal_w),
        .i_att_w  (i_att_w),
        .i_goal_p (i_goal_x),
        .i_att_p  (i_att_x),
        .i_goal_q (i_goal_y),
        .i_att_q  (i_att_y),
        .i_goal_r (i_goal_z),
        .i_att_r  (i_att_z),
        .i_rate   (i_rate_roll),
        .i_rate_a (i_rate_pitch),
        .i_rate_b (i_rate_yaw),
        .o_torque (w_tq_roll)
    );

    bat_lane u_lane_pitch (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_gain   (w_gain),
        .i_axis   (w_axis_pitch),
        .i_goal_w (i_goal_w),
        .i_att_w  (i_att_w),
        .i_goal_p (i_goal_y),
        .i_att_p  (i_att_y),
        .i_goal_q (i_goal_z),
        .i_att_q  (i_att_z),
        .i_goal_r (i_goal_x),
        .i_att_r  (i_att_x),
        .i_rate   (i_rate_pitch),
        .i_rate_a (i_rate_roll),
        .i_rate_b (i_rate_yaw),
        .o_torque (w_tq_pitch)
    );

    bat_lane u_lane_yaw (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_gain   (w_gain),
        .i_axis   (w_axis_yaw),
        .i_goal_w (i_goal_w),
        .i_att_w  (i_att_w),
        .i_goal_p (i_goal_z),
        .i_att_p  (i_att_z),
        .i_goal_q (i_goal_x),
        .i_att_q  (i_att_x),
        .i_goal_r (i_goal_y),
        .i_att_r  (i_att_y),
        .i_rate   (i_rate_yaw),
        .i_rate_a (i_rate_roll),
        .i_rate_b (i_rate_pitch),
        .o_torque (w_tq_yaw)
    );

    // ---------------- merge and output register ----------------
    bat_merge u_merge (
        .i_clk          (i_clk),
        .i_ctl          (w_ctl),
        .i_torque_roll  (w_tq_roll),
        .i_torque_pitch (w_tq_pitch),
        .i_torque_yaw   (w_tq_yaw),
        .i_thrust       (r_thrust[LS-1]),
        .o_torque_roll  (o_torque_roll),
        .o_torque_pitch (o_torque_pitch),
        .o_torque_yaw   (o_torque_yaw),
        .o_thrust_out   (o_thrust_out)
    );

endmodule

[rtl/bat_lane.sv]
// one axis lane: quaternion error, backstepping law, inertia and output scaling
// twelve register stages; depends on bat_pkg
`timescale 1ns / 1ps

module bat_lane (
    input  logic                  i_clk,
    input  bat_pkg::t_pipe_ctl    i_ctl,
    input  bat_pkg::t_gain_cfg    i_gain,
    input  bat_pkg::t_axis_cfg    i_axis,
    input  logic signed [15:0]    i_goal_w,
    input  logic signed [15:0]    i_att_w,
    input  logic signed [15:0]    i_goal_p,
    input  logic signed [15:0]    i_att_p,
    input  logic signed [15:0]    i_goal_q,
    input  logic signed [15:0]    i_att_q,
    input  logic signed [15:0]    i_goal_r,
    input  logic signed [15:0]    i_att_r,
    input  logic signed [21:0]    i_rate,
    input  logic signed [21:0]    i_rate_a,
    input  logic signed [21:0]    i_rate_b,
    output logic signed [47:0]    o_torque
);

    // stage 1: error products, gain product, gyro rate product
    logic signed [31:0] r_s1_p0, r_s1_p1, r_s1_p2, r_s1_p3;
    logic        [47:0] r_s1_kvka;
    logic signed [43:0] r_s1_ww;
    logic signed [21:0] r_s1_rate;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[0]) begin
            r_s1_p0   <= i_goal_w * i_att_p;
            r_s1_p1   <= i_att_w * i_goal_p;
            r_s1_p2   <= i_goal_r * i_att_q;
            r_s1_p3   <= i_goal_q * i_att_r;
            r_s1_kvka <= i_gain.kv * i_gain.ka;
            r_s1_ww   <= i_rate_a * i_rate_b;
            r_s1_rate <= i_rate;
        end
    end

    // stage 2: error sum, combined gains, rate term, gyro term rounding
    logic signed [33:0] w_e;
    logic        [48:0] w_kvka_rnd;
    logic        [32:0] w_gk;
    logic        [24:0] w_kp;
    logic signed [47:0] w_kprate;
    logic signed [47:0] w_a_rnd;
    logic signed [44:0] w_ww_rnd;

    assign w_e        = 34'(r_s1_p0) - 34'(r_s1_p1) + 34'(r_s1_p2) - 34'(r_s1_p3);
    assign w_kvka_rnd = 49'(r_s1_kvka) + 49'd32768;
    assign w_gk       = 33'(w_kvka_rnd >> 16) + 33'd65536;
    assign w_kp       = 25'(i_gain.kv) + 25'(i_gain.ka);
    assign w_kprate   = $signed({1'b0, w_kp}) * r_s1_rate;
    assign w_a_rnd    = w_kprate + 48'sd8;
    assign w_ww_rnd   = 45'(r_s1_ww) + 45'sd32768;

    logic signed [33:0] r_s2_e;
    logic        [32:0] r_s2_gk;
    logic signed [43:0] r_s2_a;
    logic signed [27:0] r_s2_ww16;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[1]) begin
            r_s2_e    <= w_e;
            r_s2_gk   <= w_gk;
            r_s2_a    <= 44'(w_a_rnd >>> 4);
            r_s2_ww16 <= 28'(w_ww_rnd >>> 16);
        end
    end

    // stage 3: gain times error in two halves, inertia difference times gyro term
    logic        [16:0] w_e_lo;
    logic signed [16:0] w_e_hi;
    logic signed [28:0] w_di;

    assign w_e_lo = r_s2_e[16:0];
    assign w_e_hi = r_s2_e[33:17];
    assign w_di   = $signed({1'b0, i_axis.inertia_a}) - $signed({1'b0, i_axis.inertia_b});

    logic        [49:0] r_s3_pl;
    logic signed [50:0] r_s3_ph;
    logic signed [56:0] r_s3_d;
    logic signed [43:0] r_s3_a;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[2]) begin
            r_s3_pl <= r_s2_gk * w_e_lo;
            r_s3_ph <= $signed({1'b0, r_s2_gk}) * w_e_hi;
            r_s3_d  <= w_di * r_s2_ww16;
            r_s3_a  <= r_s2_a;
        end
    end

    // stage 4: recombine and saturate
    logic signed [67:0] w_m;
    assign w_m = (68'(r_s3_ph) <<< 17) + $signed(68'(r_s3_pl));

    logic signed [63:0] r_s4_m;
    logic signed [56:0] r_s4_d;
    logic signed [43:0] r_s4_a;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[3]) begin
            r_s4_m <= bat_pkg::clamp62(w_m);
            r_s4_d <= r_s3_d;
            r_s4_a <= r_s3_a;
        end
    end

    // stage 5: round error term to q.28
    logic signed [63:0] w_b_rnd;
    assign w_b_rnd = r_s4_m + 64'sd32768;

    logic signed [47:0] r_s5_b;
    logic signed [56:0] r_s5_d;
    logic signed [43:0] r_s5_a;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[4]) begin
            r_s5_b <= 48'(w_b_rnd >>> 16);
            r_s5_d <= r_s4_d;
            r_s5_a <= r_s4_a;
        end
    end

    // stage 6: virtual control sum, round to q.16
    logic signed [48:0] w_v;
    logic signed [48:0] w_v_rnd;
    assign w_v     = 49'(r_s5_a) + 49'(r_s5_b);
    assign w_v_rnd = w_v + 49'sd2048;

    logic signed [36:0] r_s6_v16;
    logic signed [56:0] r_s6_d;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[5]) begin
            r_s6_v16 <= 37'(w_v_rnd >>> 12);
            r_s6_d   <= r_s5_d;
        end
    end

    // stage 7: inertia times virtual control in two halves
    logic        [17:0] w_v_lo;
    logic signed [18:0] w_v_hi;
    assign w_v_lo = r_s6_v16[17:0];
    assign w_v_hi = r_s6_v16[36:18];

    logic        [45:0] r_s7_pl;
    logic signed [47:0] r_s7_ph;
    logic signed [56:0] r_s7_d;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[6]) begin
            r_s7_pl <= i_axis.inertia * w_v_lo;
            r_s7_ph <= $signed({1'b0, i_axis.inertia}) * w_v_hi;
            r_s7_d  <= r_s6_d;
        end
    end

    // stage 8: recombine and saturate
    logic signed [67:0] w_iv;
    assign w_iv = (68'(r_s7_ph) <<< 18) + $signed(68'(r_s7_pl));

    logic signed [63:0] r_s8_s;
    logic signed [56:0] r_s8_d;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[7]) begin
            r_s8_s <= bat_pkg::clamp62(w_iv);
            r_s8_d <= r_s7_d;
        end
    end

    // stage 9: add gyroscopic term, saturate
    logic signed [67:0] w_sd;
    assign w_sd = 68'(r_s8_s) + 68'(r_s8_d);

    logic signed [63:0] r_s9_s;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[8]) begin
            r_s9_s <= bat_pkg::clamp62(w_sd);
        end
    end

    // stage 10: negate and round to q.16
    logic signed [64:0] w_t_rnd;
    assign w_t_rnd = 65'sd8388608 - 65'(r_s9_s);

    logic signed [39:0] r_s10_t;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[9]) begin
            r_s10_t <= 40'(w_t_rnd >>> 24);
        end
    end

    // stage 11: output scale in two halves
    logic        [19:0] w_t_lo;
    logic signed [19:0] w_t_hi;
    assign w_t_lo = r_s10_t[19:0];
    assign w_t_hi = r_s10_t[39:20];

    logic        [43:0] r_s11_pl;
    logic signed [44:0] r_s11_ph;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[10]) begin
            r_s11_pl <= w_t_lo * i_gain.scale;
            r_s11_ph <= w_t_hi * $signed({1'b0, i_gain.scale});
        end
    end

    // stage 12: recombine and round to q.16, 48 bits wide (q32.16)
    logic signed [65:0] w_r;
    logic signed [65:0] w_r_rnd;
    assign w_r     = (66'(r_s11_ph) <<< 20) + $signed(66'(r_s11_pl));
    assign w_r_rnd = w_r + 66'sd32768;

    logic signed [47:0] r_s12_r;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[11]) begin
            r_s12_r <= 48'(w_r_rnd >>> 16);
        end
    end

    assign o_torque = r_s12_r;

endmodule

[rtl/bat_merge.sv]
// merge stage: saturates the three lane torques to 32 bits and registers the result beat
// depends on bat_pkg
`timescale 1ns / 1ps

module bat_merge (
    input  logic                  i_clk,
    input  bat_pkg::t_pipe_ctl    i_ctl,
    input  logic signed [47:0]    i_torque_roll,
    input  logic signed [47:0]    i_torque_pitch,
    input  logic signed [47:0]    i_torque_yaw,
    input  logic signed [15:0]    i_thrust,
    output logic signed [31:0]    o_torque_roll,
    output logic signed [31:0]    o_torque_pitch,
    output logic signed [31:0]    o_torque_yaw,
    output logic signed [15:0]    o_thrust_out
);

    localparam logic signed [47:0] MAX32 = 48'sd2147483647;
    localparam logic signed [47:0] MIN32 = -48'sd2147483648;

    function automatic logic signed [31:0] sat32(input logic signed [47:0] x);
        logic signed [31:0] y;
        if (x > MAX32) begin
            y = 32'(MAX32);
        end else if (x < MIN32) begin
            y = 32'(MIN32);
        end else begin
            y = 32'(x);
        end
        return y;
    endfunction

    logic signed [31:0] r_roll, r_pitch, r_yaw;
    logic signed [15:0] r_thrust;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[bat_pkg::LANE_STAGES]) begin
            r_roll   <= sat32(i_torque_roll);
            r_pitch  <= sat32(i_torque_pitch);
            r_yaw    <= sat32(i_torque_yaw);
            r_thrust <= i_thrust;
        end
    end

    assign o_torque_roll  = r_roll;
    assign o_torque_pitch = r_pitch;
    assign o_torque_yaw   = r_yaw;
    assign o_thrust_out   = r_thrust;

endmodule

[bench/backstepping_attitude_torque_test.sv]
// self-checking testbench for the backstepping attitude torque block
// drives samples and gain/inertia writes, predicts each torque beat in fixed point
// depends on bat_pkg and the backstepping_attitude_torque rtl
`timescale 1ns / 1ps

module backstepping_attitude_torque_test;

    // wide signed scratch type, holds any intermediate product exactly
    typedef logic signed [127:0] t_wide;

    localparam t_wide SAT_BOUND = t_wide'(1) <<< 62;
    localparam t_wide TORQUE_HI = (t_wide'(1) <<< 31) - 1;
    localparam t_wide TORQUE_LO = -(t_wide'(1) <<< 31);

    // register slots past the last real register, writes there must be dropped
    localparam logic [2:0] REG_UNMAPPED_LO = 3'd6;
    localparam logic [2:0] REG_UNMAPPED_HI = 3'd7;

    // handy field values
    localparam logic signed [15:0] Q14_ONE  = 16'sd16384;
    localparam logic signed [15:0] Q14_MONE = -16'sd16384;
    localparam logic signed [15:0] Q14_TOP  = 16'sh7fff;
    localparam logic signed [15:0] Q14_BOT  = 16'sh8000;
    localparam logic signed [21:0] RATE_MAX = 22'sh1fffff;
    localparam logic signed [21:0] RATE_MIN = 22'sh200000;

    // pipeline latency plus a little margin, used for settling
    localparam int SETTLE_CYCLES = bat_pkg::NSTAGE + 4;

    typedef struct {
        logic signed [15:0] aw, ax, ay, az;
        logic signed [15:0] gw, gx, gy, gz;
        logic signed [21:0] wr, wp, wy;
        logic signed [15:0] thrust;
    } t_sample;

    typedef struct {
        logic signed [31:0] roll, pitch, yaw;
        logic signed [15:0] thrust;
    } t_torque;

    logic                         i_clk   = 1'b0;
    logic                         i_rst_n = 1'b0;

    // configuration port
    logic                         psel    = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite  = 1'b0;
    logic [bat_pkg::ADDR_W-1:0]   paddr   = '0;
    logic [bat_pkg::DATA_W-1:0]   pwdata  = '0;
    logic [bat_pkg::DATA_W-1:0]   prdata;
    logic                         pready;

    // sample channel
    logic                 i_valid      = 1'b0;
    logic                 o_stall;
    logic signed [15:0]   i_att_w      = '0;
    logic signed [15:0]   i_att_x      = '0;
    logic signed [15:0]   i_att_y      = '0;
    logic signed [15:0]   i_att_z      = '0;
    logic signed [15:0]   i_goal_w     = '0;
    logic signed [15:0]   i_goal_x     = '0;
    logic signed [15:0]   i_goal_y     = '0;
    logic signed [15:0]   i_goal_z     = '0;
    logic signed [21:0]   i_rate_roll  = '0;
    logic signed [21:0]   i_rate_pitch = '0;
    logic signed [21:0]   i_rate_yaw   = '0;
    logic signed [15:0]   i_thrust_in  = '0;

    // torque channel
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic signed [31:0]   o_torque_roll;
    logic signed [31:0]   o_torque_pitch;
    logic signed [31:0]   o_torque_yaw;
    logic signed [15:0]   o_thrust_out;

    // shadow copy of the register file
    logic [27:0]          cfg_inertia_roll  = bat_pkg::INERTIA_RST;
    logic [27:0]          cfg_inertia_pitch = bat_pkg::INERTIA_RST;
    logic [27:0]          cfg_inertia_yaw   = bat_pkg::INERTIA_RST;
    logic [23:0]          cfg_kv            = bat_pkg::GAIN_RST;
    logic [23:0]          cfg_ka            = bat_pkg::GAIN_RST;
    logic [23:0]          cfg_scale         = bat_pkg::SCALE_RST;

    // torque beats still owed by the block, oldest first
    t_torque              torque_due[$];

    int                   error_count = 0;
    int                   gap_pct     = 0;   // chance the sender idles a cycle
    int                   stall_pct   = 0;   // chance the receiver stalls a cycle

    backstepping_attitude_torque u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_att_w        (i_att_w),
        .i_att_x        (i_att_x),
        .i_att_y        (i_att_y),
        .i_att_z        (i_att_z),
        .i_goal_w       (i_goal_w),
        .i_goal_x       (i_goal_x),
        .i_goal_y       (i_goal_y),
        .i_goal_z       (i_goal_z),
        .i_rate_roll    (i_rate_roll),
        .i_rate_pitch   (i_rate_pitch),
        .i_rate_yaw     (i_rate_yaw),
        .i_thrust_in    (i_thrust_in),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_torque_roll  (o_torque_roll),
        .o_torque_pitch (o_torque_pitch),
        .o_torque_yaw   (o_torque_yaw),
        .o_thrust_out   (o_thrust_out)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // fixed-point torque predictor
    // ------------------------------------------------------------------

    // clip to +-2^62, the bound the rounded, multiplied and added terms are held to
    function automatic t_wide lim62(input t_wide x);
        t_wide y;
        if (x > SAT_BOUND) begin
            y = SAT_BOUND;
        end else if (x < -SAT_BOUND) begin
            y = -SAT_BOUND;
        end else begin
            y = x;
        end
        return y;
    endfunction

    // drop n fraction bits, ties go toward plus infinity
    function automatic t_wide rnd_shift(input t_wide x, input int n);
        return (lim62(x) + (t_wide'(1) <<< (n - 1))) >>> n;
    endfunction

    function automatic t_wide mul62(input t_wide a, input t_wide b);
        return lim62(a * b);
    endfunction

    function automatic t_wide add62(input t_wide a, input t_wide b);
        return lim62(lim62(a) + lim62(b));
    endfunction

    // one axis: rate and attitude feedback, gyroscopic term, output scale
    function automatic logic signed [31:0] lane_torque(input t_wide inertia,
                                                       input t_wide d_inertia,
                                                       input t_wide err,
                                                       input t_wide rate,
                                                       input t_wide ra,
                                                       input t_wide rb);
        t_wide kv, ka, scale, kp, gk, v, v16, ww16, s, t, r;
        kv    = cfg_kv;
        ka    = cfg_ka;
        scale = cfg_scale;
        kp    = kv + ka;                            // Q.16
        gk    = 65536 + rnd_shift(kv * ka, 16);     // 1 + kv*ka, Q.16
        v     = add62(rnd_shift(kp * rate, 4), rnd_shift(mul62(gk, err), 16));  // Q.28
        v16   = rnd_shift(v, 12);
        ww16  = rnd_shift(ra * rb, 16);
        s     = add62(mul62(inertia, v16), mul62(d_inertia, ww16));            // Q.40
        t     = rnd_shift(-s, 24);
        r     = rnd_shift(mul62(t, scale), 16);
        if (r > TORQUE_HI) begin
            r = TORQUE_HI;
        end else if (r < TORQUE_LO) begin
            r = TORQUE_LO;
        end
        return r[31:0];
    endfunction

    function automatic t_torque predict_torque(input t_sample s);
        t_wide aw, ax, ay, az, gw, gx, gy, gz;
        t_wide w1, w2, w3, ix, iy, iz;
        t_wide e_roll, e_pitch, e_yaw;
        t_torque r;
        aw = s.aw; ax = s.ax; ay = s.ay; az = s.az;
        gw = s.gw; gx = s.gx; gy = s.gy; gz = s.gz;
        w1 = s.wr; w2 = s.wp; w3 = s.wy;
        ix = cfg_inertia_roll;
        iy = cfg_inertia_pitch;
        iz = cfg_inertia_yaw;
        // vector part of the attitude error quaternion, Q.28
        e_roll  = gw * ax - aw * gx + gz * ay - gy * az;
        e_pitch = gw * ay - aw * gy + gx * az - gz * ax;
        e_yaw   = gw * az - aw * gz + gy * ax - gx * ay;
        r.roll   = lane_torque(ix, iy - iz, e_roll, w1, w2, w3);
        r.pitch  = lane_torque(iy, iz - ix, e_pitch, w2, w1, w3);
        r.yaw    = lane_torque(iz, ix - iy, e_yaw, w3, w1, w2);
        r.thrust = s.thrust;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic t_sample mk(input logic signed [15:0] aw, ax, ay, az,
                                   input logic signed [15:0] gw, gx, gy, gz,
                                   input logic signed [21:0] wr, wp, wy,
                                   input logic signed [15:0] thrust);
        t_sample s;
        s.aw = aw; s.ax = ax; s.ay = ay; s.az = az;
        s.gw = gw; s.gx = gx; s.gy = gy; s.gz = gz;
        s.wr = wr; s.wp = wp; s.wy = wy;
        s.thrust = thrust;
        return s;
    endfunction

    // mostly in range, some raw bit patterns, some edge values
    function automatic logic signed [15:0] rand_q14();
        logic signed [15:0] v;
        int pick;
        pick = $urandom_range(9);
        if (pick < 6) begin
            v = 16'(int'($urandom_range(32768)) - 16384);
        end else if (pick < 8) begin
            v = 16'($urandom);
        end else begin
            case ($urandom_range(4))
                0:       v = Q14_ONE;
                1:       v = Q14_MONE;
                2:       v = Q14_TOP;
                3:       v = Q14_BOT;
                default: v = '0;
            endcase
        end
        return v;
    endfunction

    // mostly a few rad/s, sometimes anything the field holds
    function automatic logic signed [21:0] rand_rate();
        logic signed [21:0] v;
        int pick;
        pick = $urandom_range(9);
        if (pick < 7) begin
            v = 22'(int'($urandom_range(1 << 19)) - (1 << 18));
        end else if (pick < 9) begin
            v = 22'($urandom);
        end else begin
            case ($urandom_range(2))
                0:       v = RATE_MAX;
                1:       v = RATE_MIN;
                default: v = '0;
            endcase
        end
        return v;
    endfunction

    function automatic logic signed [15:0] nudge(input logic signed [15:0] v);
        return v + 16'($urandom_range(64)) - 16'd32;
    endfunction

    function automatic t_sample rand_sample();
        t_sample s;
        s.aw = rand_q14(); s.ax = rand_q14(); s.ay = rand_q14(); s.az = rand_q14();
        // a quarter of the time the goal sits close to the attitude
        if ($urandom_range(3) == 0) begin
            s.gw = nudge(s.aw); s.gx = nudge(s.ax);
            s.gy = nudge(s.ay); s.gz = nudge(s.az);
        end else begin
            s.gw = rand_q14(); s.gx = rand_q14(); s.gy = rand_q14(); s.gz = rand_q14();
        end
        s.wr = rand_rate(); s.wp = rand_rate(); s.wy = rand_rate();
        s.thrust = rand_q14();
        return s;
    endfunction

    // register value: zero, all ones, raw 32 bits (upper bits must be dropped)
    // or a plausible magnitude
    function automatic logic [31:0] rand_reg(input int width);
        logic [31:0] v;
        case ($urandom_range(7))
            0:       v = '0;
            1:       v = (32'd1 << width) - 1;
            2:       v = $urandom;
            default: v = $urandom_range(1 << (width - 6));
        endcase
        return v;
    endfunction

    task automatic report_error(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // apb write: setup cycle then access cycle, shadow copy follows,
    // then the register is read back at the same address
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        logic [31:0] rd_want;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        case (idx)
            bat_pkg::REG_INERTIA_ROLL:  cfg_inertia_roll  = val[27:0];
            bat_pkg::REG_INERTIA_PITCH: cfg_inertia_pitch = val[27:0];
            bat_pkg::REG_INERTIA_YAW:   cfg_inertia_yaw   = val[27:0];
            bat_pkg::REG_GAIN_VELOCITY: cfg_kv            = val[23:0];
            bat_pkg::REG_GAIN_ATTITUDE: cfg_ka            = val[23:0];
            bat_pkg::REG_OUTPUT_SCALE:  cfg_scale         = val[23:0];
            default: ;   // unmapped slot, nothing changes
        endcase
        case (idx)
            bat_pkg::REG_INERTIA_ROLL:  rd_want = 32'(cfg_inertia_roll);
            bat_pkg::REG_INERTIA_PITCH: rd_want = 32'(cfg_inertia_pitch);
            bat_pkg::REG_INERTIA_YAW:   rd_want = 32'(cfg_inertia_yaw);
            bat_pkg::REG_GAIN_VELOCITY: rd_want = 32'(cfg_kv);
            bat_pkg::REG_GAIN_ATTITUDE: rd_want = 32'(cfg_ka);
            bat_pkg::REG_OUTPUT_SCALE:  rd_want = 32'(cfg_scale);
            default:                    rd_want = '0;
        endcase
        if (prdata !== rd_want)
            report_error($sformatf("register %0d reads %0h, expected %0h",
                                   idx, prdata, rd_want));
    endtask

    task automatic load_config(input logic [31:0] i_r, i_p, i_y, kv, ka, scale);
        write_reg(bat_pkg::REG_INERTIA_ROLL, i_r);
        write_reg(bat_pkg::REG_INERTIA_PITCH, i_p);
        write_reg(bat_pkg::REG_INERTIA_YAW, i_y);
        write_reg(bat_pkg::REG_GAIN_VELOCITY, kv);
        write_reg(bat_pkg::REG_GAIN_ATTITUDE, ka);
        write_reg(bat_pkg::REG_OUTPUT_SCALE, scale);
    endtask

    // one sample beat; valid is left high so back-to-back beats need no gap
    task automatic send_sample(input t_sample s);
        t_torque want;
        while ($urandom_range(99) < gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        want = predict_torque(s);
        i_valid      <= 1'b1;
        i_att_w      <= s.aw;
        i_att_x      <= s.ax;
        i_att_y      <= s.ay;
        i_att_z      <= s.az;
        i_goal_w     <= s.gw;
        i_goal_x     <= s.gx;
        i_goal_y     <= s.gy;
        i_goal_z     <= s.gz;
        i_rate_roll  <= s.wr;
        i_rate_pitch <= s.wp;
        i_rate_yaw   <= s.wy;
        i_thrust_in  <= s.thrust;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        torque_due.push_back(want);
    endtask

    // stop sending and wait until every owed beat is out and the pipe is empty
    task automatic drain_results();
        i_valid <= 1'b0;
        while (torque_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // torque beat checker and receiver stalls
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        t_torque want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (torque_due.size() == 0) begin
                report_error("torque beat with nothing outstanding");
            end else begin
                want = torque_due.pop_front();
                if (o_torque_roll !== want.roll)
                    report_error($sformatf("roll torque %0d, expected %0d",
                                           o_torque_roll, want.roll));
                if (o_torque_pitch !== want.pitch)
                    report_error($sformatf("pitch torque %0d, expected %0d",
                                           o_torque_pitch, want.pitch));
                if (o_torque_yaw !== want.yaw)
                    report_error($sformatf("yaw torque %0d, expected %0d",
                                           o_torque_yaw, want.yaw));
                if (o_thrust_out !== want.thrust)
                    report_error($sformatf("thrust %0d, expected %0d",
                                           o_thrust_out, want.thrust));
            end
        end
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // edge samples, reused under each extreme register setting
    task automatic send_extremes();
        send_sample(mk(Q14_ONE, Q14_ONE, Q14_ONE, Q14_ONE, Q14_MONE, Q14_ONE, Q14_MONE,
                       Q14_ONE, RATE_MAX, RATE_MAX, RATE_MAX, Q14_ONE));
        send_sample(mk(Q14_MONE, Q14_MONE, Q14_MONE, Q14_MONE, Q14_ONE, Q14_ONE, Q14_ONE,
                       Q14_ONE, RATE_MIN, RATE_MIN, RATE_MAX, Q14_MONE));
        send_sample(mk(Q14_TOP, Q14_BOT, Q14_TOP, Q14_BOT, Q14_BOT, Q14_TOP, Q14_BOT,
                       Q14_TOP, RATE_MAX, RATE_MIN, RATE_MIN, Q14_BOT));
    endtask

    // reset register values, field extremes and raw out-of-range patterns
    task automatic test_reset_values();
        send_sample(mk('0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0));
        // identity attitude on target, no motion
        send_sample(mk(Q14_ONE, '0, '0, '0, Q14_ONE, '0, '0, '0, '0, '0, '0, Q14_ONE));
        // half turn about each axis
        send_sample(mk(Q14_ONE, '0, '0, '0, '0, Q14_ONE, '0, '0, '0, '0, '0, Q14_MONE));
        send_sample(mk(Q14_ONE, '0, '0, '0, '0, '0, Q14_ONE, '0, '0, '0, '0, Q14_TOP));
        send_sample(mk(Q14_ONE, '0, '0, '0, '0, '0, '0, Q14_MONE, '0, '0, '0, Q14_BOT));
        // rates alone
        send_sample(mk(Q14_ONE, '0, '0, '0, Q14_ONE, '0, '0, '0,
                       RATE_MAX, RATE_MIN, RATE_MAX, '0));
        send_extremes();
        drain_results();
    endtask

    // register extremes: everything at max, zero inertia, everything zero
    task automatic test_config_extremes();
        load_config('1, '1, '1, '1, '1, '1);
        send_extremes();
        drain_results();
        // zero inertia on roll and yaw, max on pitch, so gyroscopic terms peak
        load_config('0, 32'h0fff_ffff, '0, 32'h0001_0000, 32'h0004_0000, 32'h0000_0100);
        send_extremes();
        drain_results();
        load_config('0, '0, '0, '0, '0, '0);
        send_extremes();
        drain_results();
    endtask

    // writes to unmapped slots must leave the real registers alone
    task automatic test_unmapped_register();
        load_config(32'd167772, 32'd201327, 32'd335544,
                    32'h0002_0000, 32'h0003_0000, 32'h0000_8000);
        write_reg(REG_UNMAPPED_LO, '1);
        write_reg(REG_UNMAPPED_HI, '1);
        send_sample(mk(Q14_ONE, 16'sd1000, -16'sd2000, 16'sd500, Q14_ONE, '0, '0, '0,
                       22'sd65536, -22'sd32768, 22'sd131072, 16'sd8192));
        send_extremes();
        drain_results();
    endtask

    // random samples under random register settings with the given idling
    task automatic test_random_traffic(input int send_gap, input int recv_stall);
        int pause_at;
        gap_pct   = send_gap;
        stall_pct = recv_stall;
        for (int half = 0; half < 2; half++) begin
            load_config(rand_reg(28), rand_reg(28), rand_reg(28),
                        rand_reg(24), rand_reg(24), rand_reg(24));
            // one pause somewhere in the middle lets the pipe run dry
            pause_at = $urandom_range(20, 110);
            for (int n = 0; n < 133; n++) begin
                if (n == pause_at)
                    drain_results();
                send_sample(rand_sample());
            end
            drain_results();
        end
    endtask

    // ------------------------------------------------------------------
    // run
    // ------------------------------------------------------------------

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        gap_pct   = 19;
        stall_pct = 64;
        test_reset_values();
        test_config_extremes();
        test_unmapped_register();
        test_random_traffic(19, 64);
        test_random_traffic(64, 19);
        test_random_traffic(0, 0);
        if (error_count == 0) begin
            $display("backstepping_attitude_torque_test: done, clean");
        end else begin
            $display("backstepping_attitude_torque_test: done, errors");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("backstepping_attitude_torque_test: done, errors");
        $finish;
    end

endmodule

[files.f]
rtl/bat_pkg.sv
rtl/bat_lane.sv
rtl/bat_merge.sv
rtl/backstepping_attitude_torque.sv
bench/backstepping_attitude_torque_test.sv
